// File: design/assert_macros.svh
// Shared assertion macros for the cull test checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define FC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/fcull_pkg.sv
`timescale 1ns / 1ps

package fcull_pkg;

  // Geometry widths.
  localparam int COORD_WIDTH = 16;
  localparam int RAD_W       = COORD_WIDTH - 1;
  localparam int NORM_W      = 16;               // Q2.14 normal component
  localparam int OFS_W       = 16;               // Q12.4 offset
  localparam int FRAC_SHIFT  = 14;               // scales Q.4 up to Q.18
  localparam int NUM_FACES   = 6;

  // Coefficient register layout.
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = $clog2(NUM_FACES);
  localparam int NX_LSB    = 0;
  localparam int NY_LSB    = 16;
  localparam int NZ_LSB    = 32;
  localparam int OFS_LSB   = 48;

  // Arithmetic widths.
  localparam int PROD_W = COORD_WIDTH + NORM_W;
  localparam int THR_W  = ((COORD_WIDTH > OFS_W) ? COORD_WIDTH : OFS_W) + 1;
  localparam int CMP_W  = (((PROD_W + 2) > (THR_W + FRAC_SHIFT)) ?
                           (PROD_W + 2) : (THR_W + FRAC_SHIFT)) + 1;

  // Stream packing: kind travels in tuser, geometry in tdata.
  localparam int KIND_W    = 2;
  localparam int S_TUSER_W = KIND_W;
  localparam int IN_BITS   = 6 * COORD_WIDTH + RAD_W;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = 8;

  localparam int POS_X_LSB  = 0;
  localparam int POS_Y_LSB  = COORD_WIDTH;
  localparam int POS_Z_LSB  = 2 * COORD_WIDTH;
  localparam int FAR_X_LSB  = 3 * COORD_WIDTH;
  localparam int FAR_Y_LSB  = 4 * COORD_WIDTH;
  localparam int FAR_Z_LSB  = 5 * COORD_WIDTH;
  localparam int RADIUS_LSB = 6 * COORD_WIDTH;

  typedef enum logic [KIND_W-1:0] {
    KIND_NOOP   = 2'd0,
    KIND_SPHERE = 2'd1,
    KIND_BOX    = 2'd2,
    KIND_POINT  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                         kind;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] far_x;
    logic signed [COORD_WIDTH-1:0] far_y;
    logic signed [COORD_WIDTH-1:0] far_z;
    logic        [RAD_W-1:0]       radius;
    logic                          visible;
  } item_t;

  // Coordinate that maximizes coord * n along one axis for a box; the
  // given position for every other kind.
  function automatic logic signed [COORD_WIDTH-1:0] pick_coord(
    input kind_e                         kind,
    input logic signed [COORD_WIDTH-1:0] lo,
    input logic signed [COORD_WIDTH-1:0] hi,
    input logic                          n_neg
  );
    logic signed [COORD_WIDTH-1:0] big;
    logic signed [COORD_WIDTH-1:0] sml;
    big = (lo > hi) ? lo : hi;
    sml = (lo > hi) ? hi : lo;
    if (kind == KIND_BOX) begin
      return n_neg ? sml : big;
    end
    return lo;
  endfunction

endpackage

// File: design/frustum_cull_test.sv
// Each input transfer passes through two register stages per face cell on its way to the result.
// Throughput: one collider per cycle; each cell stage advances whenever the stage after it
// is empty or moving, so a stalled result still lets earlier stages fill.
// Reset (rst_ni low, asynchronous): all stage valids clear and every face coefficient
// register returns to zero, which makes points, boxes and nonzero-radius spheres visible.
`timescale 1ns / 1ps

module frustum_cull_test import fcull_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Collider stream in.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // From bit 0 up: pos_x, pos_y, pos_z, far_x, far_y, far_z, radius, zero fill.
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // From bit 0 up: kind.
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  // Visibility stream out.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // From bit 0 up: visible, zero fill.
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // Face coefficient writes: index 0 left, 1 right, 2 top, 3 bottom, 4 near, 5 far.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // The collider travels down a row of six cells, one per face. Each cell
  // owns its face coefficients, tests the collider against them and clears
  // the running visible flag on a miss before handing the item on.
  item_t chain_item  [NUM_FACES+1];
  logic  chain_valid [NUM_FACES+1];
  logic  chain_ready [NUM_FACES+1];

  // Unpack the input transfer; the running flag starts out visible.
  always_comb begin
    chain_item[0].kind    = kind_e'(s_axis_tuser);
    chain_item[0].pos_x   = s_axis_tdata[POS_X_LSB +: COORD_WIDTH];
    chain_item[0].pos_y   = s_axis_tdata[POS_Y_LSB +: COORD_WIDTH];
    chain_item[0].pos_z   = s_axis_tdata[POS_Z_LSB +: COORD_WIDTH];
    chain_item[0].far_x   = s_axis_tdata[FAR_X_LSB +: COORD_WIDTH];
    chain_item[0].far_y   = s_axis_tdata[FAR_Y_LSB +: COORD_WIDTH];
    chain_item[0].far_z   = s_axis_tdata[FAR_Z_LSB +: COORD_WIDTH];
    chain_item[0].radius  = s_axis_tdata[RADIUS_LSB +: RAD_W];
    chain_item[0].visible = 1'b1;
  end

  assign chain_valid[0] = s_axis_tvalid;
  assign s_axis_tready  = chain_ready[0];

  for (genvar k = 0; k < NUM_FACES; k++) begin : g_cell
    logic cell_we;

    // Write only the cell whose index matches; indexes past the last face drop.
    assign cell_we = cfg_we_i && (cfg_idx_i == CFG_IDX_W'(k));

    fcull_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cfg_we_i   (cell_we),
      .cfg_data_i (cfg_data_i),
      .valid_i    (chain_valid[k]),
      .ready_o    (chain_ready[k]),
      .item_i     (chain_item[k]),
      .valid_o    (chain_valid[k+1]),
      .ready_i    (chain_ready[k+1]),
      .item_o     (chain_item[k+1])
    );
  end

  // The last cell's second stage is the output register.
  assign m_axis_tvalid          = chain_valid[NUM_FACES];
  assign chain_ready[NUM_FACES] = m_axis_tready;
  assign m_axis_tdata           = M_TDATA_W'(chain_item[NUM_FACES].visible);

endmodule

// File: design/fcull_cell.sv
`timescale 1ns / 1ps

module fcull_cell import fcull_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  item_t            item_i,
  output logic             valid_o,
  input  logic             ready_i,
  output item_t            item_o
);

  logic [CFG_W-1:0] face_q;

  logic signed [NORM_W-1:0] nx, ny, nz;
  logic signed [OFS_W-1:0]  ofs;

  logic signed [COORD_WIDTH-1:0] cx, cy, cz;
  logic signed [PROD_W-1:0]      px_d, py_d, pz_d;
  logic signed [THR_W-1:0]       thr_d;

  logic                     a_valid_q;
  item_t                    a_item_q;
  logic signed [PROD_W-1:0] a_px_q, a_py_q, a_pz_q;
  logic signed [THR_W-1:0]  a_thr_q;

  logic  b_valid_q;
  item_t b_item_q;

  logic                    adv_b;
  logic                    load_a;
  logic signed [CMP_W-1:0] sum;
  logic signed [CMP_W-1:0] lim;
  logic                    pass;
  item_t                   b_item_d;

  assign nx  = face_q[NX_LSB +: NORM_W];
  assign ny  = face_q[NY_LSB +: NORM_W];
  assign nz  = face_q[NZ_LSB +: NORM_W];
  assign ofs = face_q[OFS_LSB +: OFS_W];

  // Stage A: pick the corner and form the three axis products.
  assign cx = pick_coord(item_i.kind, item_i.pos_x, item_i.far_x, nx[NORM_W-1]);
  assign cy = pick_coord(item_i.kind, item_i.pos_y, item_i.far_y, ny[NORM_W-1]);
  assign cz = pick_coord(item_i.kind, item_i.pos_z, item_i.far_z, nz[NORM_W-1]);

  assign px_d = PROD_W'(cx) * PROD_W'(nx);
  assign py_d = PROD_W'(cy) * PROD_W'(ny);
  assign pz_d = PROD_W'(cz) * PROD_W'(nz);

  // A sphere folds its radius into the threshold.
  assign thr_d = (item_i.kind == KIND_SPHERE) ?
                 (THR_W'(ofs) - THR_W'($signed({1'b0, item_i.radius}))) :
                 THR_W'(ofs);

  // Stage B: sum and compare against the threshold at Q.18.
  assign sum = CMP_W'(a_px_q) + CMP_W'(a_py_q) + CMP_W'(a_pz_q);
  assign lim = CMP_W'(a_thr_q) <<< FRAC_SHIFT;

  always_comb begin
    case (a_item_q.kind)
      KIND_SPHERE: pass = (sum > lim);
      KIND_BOX,
      KIND_POINT:  pass = (sum >= lim);
      default:     pass = 1'b1;
    endcase
  end

  always_comb begin
    b_item_d         = a_item_q;
    b_item_d.visible = a_item_q.visible & pass;
  end

  assign adv_b   = !b_valid_q || ready_i;
  assign ready_o = !a_valid_q || adv_b;
  assign load_a  = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_q    <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        face_q <= cfg_data_i;
      end
      if (ready_o) begin
        a_valid_q <= valid_i;
      end
      if (adv_b) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_a) begin
      a_item_q <= item_i;
      a_px_q   <= px_d;
      a_py_q   <= py_d;
      a_pz_q   <= pz_d;
      a_thr_q  <= thr_d;
    end
    if (adv_b && a_valid_q) begin
      b_item_q <= b_item_d;
    end
  end

  assign valid_o = b_valid_q;
  assign item_o  = b_item_q;

endmodule

// File: design/fcull_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fcull_chk import fcull_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result.
  `FC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "stalled result dropped")
  `FC_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "stalled result changed")
  // Fill bits above the visible flag stay zero.
  `FC_ASSERT(a_out_fill, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:1] == '0), "nonzero fill in result")
  // Reset empties the pipeline: no result right after a reset edge.
  `FC_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> !m_axis_tvalid, "result shown right after reset")
  // The pipeline is empty once reset is released, so it then takes a transfer.
  `FC_ASSERT_ALWAYS(a_in_open, clk_i, !rst_ni ##1 rst_ni |-> s_axis_tready, "input blocked after reset")

endmodule

bind frustum_cull_test fcull_chk u_fcull_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
